>>> sv/rvmdu_pkg.sv
package rvmdu_pkg;

	localparam int XLEN  = 32;
	localparam int CMD_W = 3;
	localparam int REG_W = 5;
	localparam int CNT_W = $clog2(XLEN);

	typedef logic [XLEN-1:0]  word_t;
	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic [REG_W-1:0] regnum_t;

	localparam cmd_t CMD_MUL    = 3'd0;
	localparam cmd_t CMD_MULH   = 3'd1;
	localparam cmd_t CMD_MULHSU = 3'd2;
	localparam cmd_t CMD_MULHU  = 3'd3;
	localparam cmd_t CMD_DIV    = 3'd4;
	localparam cmd_t CMD_DIVU   = 3'd5;
	localparam cmd_t CMD_REM    = 3'd6;
	localparam cmd_t CMD_REMU   = 3'd7;

endpackage

>>> sv/rv32m_multiply_divide_unit_core.sv
// RV32M multiply/divide unit. One operation is taken when start is high and busy is low;
// the result and its destination register appear on result_value and result_reg for exactly
// one cycle with done high, and the receiver cannot hold it off. Every operation runs on a
// single shared 33-bit adder/subtractor stepped by a small sequencer, one operand bit per
// cycle: multiplies take 32 shift-add steps, two signed corrections and a result step
// before done; divides and remainders take a magnitude step for each operand, 32 restoring
// steps and a sign fix step. busy is high through all of these steps. Division by zero
// and signed overflow need no special timing.
module rv32m_multiply_divide_unit_core import rvmdu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	input  word_t   operand_a,
	input  word_t   operand_b,
	input  regnum_t dest_reg,
	output logic    done,
	output word_t   result_value,
	output regnum_t result_reg
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ABS_A = 3'd1;
	localparam logic [2:0] ST_ABS_B = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_FIX1  = 3'd5;
	localparam logic [2:0] ST_FIX2  = 3'd6;
	localparam logic [2:0] ST_FINAL = 3'd7;

	logic [2:0]       state_q;
	cmd_t             op_q;
	word_t            a_q;
	word_t            b_q;
	word_t            hi_q;
	word_t            lo_q;
	logic [CNT_W-1:0] cnt_q;
	regnum_t          reg_q;
	logic             neg_q;
	logic             done_q;
	word_t            res_q;
	regnum_t          res_reg_q;

	// shared adder
	logic [XLEN:0]   add_x;
	logic [XLEN:0]   add_y;
	logic            add_sub;
	logic [XLEN+1:0] add_sum;

	logic  is_div;
	logic  last_step;
	logic  div_ge;
	word_t final_sel;

	assign is_div    = op_q[2];
	assign last_step = (cnt_q == CNT_W'(XLEN - 1));
	assign final_sel = (op_q == CMD_DIV || op_q == CMD_DIVU) ? lo_q : hi_q;

	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			ST_ABS_A: begin
				add_y   = {1'b0, a_q};
				add_sub = 1'b1;
			end
			ST_ABS_B: begin
				add_y   = {1'b0, b_q};
				add_sub = 1'b1;
			end
			ST_MUL: begin
				add_x = {1'b0, hi_q};
				add_y = {1'b0, a_q};
			end
			ST_DIV: begin
				add_x   = {hi_q, lo_q[XLEN-1]};
				add_y   = {1'b0, b_q};
				add_sub = 1'b1;
			end
			ST_FIX1: begin
				add_x   = {1'b0, hi_q};
				add_y   = {1'b0, b_q};
				add_sub = 1'b1;
			end
			ST_FIX2: begin
				add_x   = {1'b0, hi_q};
				add_y   = {1'b0, a_q};
				add_sub = 1'b1;
			end
			ST_FINAL: begin
				add_y   = {1'b0, final_sel};
				add_sub = 1'b1;
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
	end

	// top bit of a subtract is the borrow
	assign add_sum = {1'b0, add_x} + ({1'b0, add_y} ^ {(XLEN+2){add_sub}})
		+ {{(XLEN+1){1'b0}}, add_sub};
	assign div_ge  = ~add_sum[XLEN+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						state_q <= cmd[2] ? ST_ABS_A : ST_MUL;
					end
				end
				ST_ABS_A: state_q <= ST_ABS_B;
				ST_ABS_B: state_q <= ST_DIV;
				ST_MUL, ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= is_div ? ST_FINAL : ST_FIX1;
					end
				end
				ST_FIX1: state_q <= ST_FIX2;
				ST_FIX2: state_q <= ST_FINAL;
				ST_FINAL: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_q  <= cmd;
					a_q   <= operand_a;
					b_q   <= operand_b;
					reg_q <= dest_reg;
					hi_q  <= '0;
					lo_q  <= operand_b;
					// sign of the final quotient or remainder
					unique case (cmd)
						CMD_DIV: neg_q <= (operand_a[XLEN-1] ^ operand_b[XLEN-1])
							&& (operand_b != '0);
						CMD_REM: neg_q <= operand_a[XLEN-1];
						default: neg_q <= 1'b0;
					endcase
				end
			end
			ST_ABS_A: begin
				if ((op_q == CMD_DIV || op_q == CMD_REM) && a_q[XLEN-1]) begin
					a_q <= add_sum[XLEN-1:0];
				end
			end
			ST_ABS_B: begin
				if ((op_q == CMD_DIV || op_q == CMD_REM) && b_q[XLEN-1]) begin
					b_q <= add_sum[XLEN-1:0];
				end
				hi_q <= '0;
				lo_q <= a_q;
			end
			ST_MUL: begin
				if (lo_q[0]) begin
					hi_q <= add_sum[XLEN:1];
					lo_q <= {add_sum[0], lo_q[XLEN-1:1]};
				end else begin
					hi_q <= {1'b0, hi_q[XLEN-1:1]};
					lo_q <= {hi_q[0], lo_q[XLEN-1:1]};
				end
			end
			ST_DIV: begin
				if (div_ge) begin
					hi_q <= add_sum[XLEN-1:0];
					lo_q <= {lo_q[XLEN-2:0], 1'b1};
				end else begin
					hi_q <= {hi_q[XLEN-2:0], lo_q[XLEN-1]};
					lo_q <= {lo_q[XLEN-2:0], 1'b0};
				end
			end
			ST_FIX1: begin
				// signed multiplicand: subtract multiplier from high half
				if ((op_q == CMD_MULH || op_q == CMD_MULHSU) && a_q[XLEN-1]) begin
					hi_q <= add_sum[XLEN-1:0];
				end
			end
			ST_FIX2: begin
				if (op_q == CMD_MULH && b_q[XLEN-1]) begin
					hi_q <= add_sum[XLEN-1:0];
				end
			end
			ST_FINAL: begin
				res_reg_q <= reg_q;
				if (is_div) begin
					res_q <= neg_q ? add_sum[XLEN-1:0] : final_sel;
				end else begin
					res_q <= (op_q == CMD_MUL) ? lo_q : hi_q;
				end
			end
			default: begin
				res_reg_q <= res_reg_q;
			end
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign result_value = res_q;
	assign result_reg   = res_reg_q;

endmodule

>>> tb/rv32m_multiply_divide_unit_core_tb.sv
`timescale 1ns / 100ps

module rv32m_multiply_divide_unit_core_tb;
	import rvmdu_pkg::*;

	localparam int N_RANDOM    = 1950;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_WAIT  = 50;

	typedef struct {
		word_t   value;
		regnum_t rd;
	} mdu_result_t;

	typedef struct {
		cmd_t    op;
		word_t   a;
		word_t   b;
		regnum_t rd;
		bit      fixed;
		word_t   want;
	} op_row_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	word_t   operand_a;
	word_t   operand_b;
	regnum_t dest_reg;
	logic    done;
	word_t   result_value;
	regnum_t result_reg;

	mdu_result_t pending_results[$];
	mdu_result_t oldest;
	mdu_result_t incoming;
	int          errors;
	int          stall_cycles;
	bit          row_fixed;
	word_t       row_want;

	rv32m_multiply_divide_unit_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.dest_reg     (dest_reg),
		.done         (done),
		.result_value (result_value),
		.result_reg   (result_reg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// magnitude of a two's complement word, as unsigned
	function automatic word_t magnitude(word_t v);
		return v[XLEN-1] ? word_t'(-v) : v;
	endfunction

	function automatic word_t rv32m_result(cmd_t op, word_t a, word_t b);
		logic [2*XLEN-1:0] a_sx;
		logic [2*XLEN-1:0] b_sx;
		logic [2*XLEN-1:0] a_zx;
		logic [2*XLEN-1:0] b_zx;
		logic [2*XLEN-1:0] prod;
		word_t             quot;
		word_t             rem;
		a_sx = {{XLEN{a[XLEN-1]}}, a};
		b_sx = {{XLEN{b[XLEN-1]}}, b};
		a_zx = {{XLEN{1'b0}}, a};
		b_zx = {{XLEN{1'b0}}, b};
		case (op)
			CMD_MUL: begin
				prod = a_zx * b_zx;
				return prod[XLEN-1:0];
			end
			CMD_MULH: begin
				prod = a_sx * b_sx;
				return prod[2*XLEN-1:XLEN];
			end
			CMD_MULHSU: begin
				prod = a_sx * b_zx;
				return prod[2*XLEN-1:XLEN];
			end
			CMD_MULHU: begin
				prod = a_zx * b_zx;
				return prod[2*XLEN-1:XLEN];
			end
			CMD_DIV: begin
				if (b == '0)
					return '1;
				if (a == {1'b1, {(XLEN-1){1'b0}}} && b == '1)
					return a;
				quot = magnitude(a) / magnitude(b);
				return (a[XLEN-1] != b[XLEN-1]) ? word_t'(-quot) : quot;
			end
			CMD_DIVU: begin
				if (b == '0)
					return '1;
				return a / b;
			end
			CMD_REM: begin
				if (b == '0)
					return a;
				if (a == {1'b1, {(XLEN-1){1'b0}}} && b == '1)
					return '0;
				rem = magnitude(a) % magnitude(b);
				return a[XLEN-1] ? word_t'(-rem) : rem;
			end
			default: begin
				if (b == '0)
					return a;
				return a % b;
			end
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	// result check first, then the transfer on the input side
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result %h rd %0d with nothing pending",
						result_value, result_reg));
				end else begin
					oldest = pending_results.pop_front();
					if (result_value !== oldest.value)
						report_mismatch($sformatf("result_value %h, expected %h",
							result_value, oldest.value));
					if (result_reg !== oldest.rd)
						report_mismatch($sformatf("result_reg %0d, expected %0d",
							result_reg, oldest.rd));
				end
			end
			if (start && !busy) begin
				incoming.value = row_fixed ? row_want : rv32m_result(cmd, operand_a, operand_b);
				incoming.rd    = dest_reg;
				pending_results.push_back(incoming);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles with no transfer", stall_cycles);
			$display("[rv32m_multiply_divide_unit_core] ERROR");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic word_t pick_operand();
		word_t corners[6];
		int    r;
		corners = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001};
		r = $urandom_range(0, 9);
		case (r)
			5:       return $urandom_range(0, 15);
			6:       return word_t'(-$urandom_range(1, 15));
			7:       return corners[$urandom_range(0, 5)];
			8:       return word_t'(1) << $urandom_range(0, XLEN-1);
			default: return $urandom();
		endcase
	endfunction

	task automatic issue_op(op_row_t row);
		int gap;
		@(negedge clk);
		start     <= 1'b1;
		cmd       <= row.op;
		operand_a <= row.a;
		operand_b <= row.b;
		dest_reg  <= row.rd;
		row_fixed  = row.fixed;
		row_want   = row.want;
		do
			@(posedge clk);
		while (busy);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	op_row_t directed_ops[] = '{
		'{CMD_MUL,    32'h0000_0000, 32'h0000_0000, 5'd0,  1'b1, 32'h0000_0000},
		'{CMD_MUL,    32'hffff_ffff, 32'hffff_ffff, 5'd31, 1'b1, 32'h0000_0001},
		'{CMD_MUL,    32'h8000_0000, 32'hffff_ffff, 5'd1,  1'b0, 32'h0},
		'{CMD_MULH,   32'h8000_0000, 32'h8000_0000, 5'd2,  1'b1, 32'h4000_0000},
		'{CMD_MULH,   32'hffff_ffff, 32'hffff_ffff, 5'd3,  1'b1, 32'h0000_0000},
		'{CMD_MULH,   32'h7fff_ffff, 32'h8000_0000, 5'd4,  1'b0, 32'h0},
		'{CMD_MULHSU, 32'hffff_ffff, 32'hffff_ffff, 5'd5,  1'b1, 32'hffff_ffff},
		'{CMD_MULHSU, 32'h7fff_ffff, 32'hffff_ffff, 5'd6,  1'b0, 32'h0},
		'{CMD_MULHU,  32'hffff_ffff, 32'hffff_ffff, 5'd7,  1'b1, 32'hffff_fffe},
		'{CMD_DIV,    32'h1234_5678, 32'h0000_0000, 5'd8,  1'b1, 32'hffff_ffff},
		'{CMD_DIVU,   32'h8765_4321, 32'h0000_0000, 5'd9,  1'b1, 32'hffff_ffff},
		'{CMD_REM,    32'h1234_5678, 32'h0000_0000, 5'd10, 1'b1, 32'h1234_5678},
		'{CMD_REMU,   32'h8765_4321, 32'h0000_0000, 5'd11, 1'b1, 32'h8765_4321},
		'{CMD_DIV,    32'h8000_0000, 32'hffff_ffff, 5'd12, 1'b1, 32'h8000_0000},
		'{CMD_REM,    32'h8000_0000, 32'hffff_ffff, 5'd13, 1'b1, 32'h0000_0000},
		'{CMD_DIVU,   32'h8000_0000, 32'hffff_ffff, 5'd14, 1'b1, 32'h0000_0000},
		'{CMD_REMU,   32'h8000_0000, 32'hffff_ffff, 5'd15, 1'b1, 32'h8000_0000},
		'{CMD_DIV,    32'hffff_fff9, 32'h0000_0002, 5'd16, 1'b1, 32'hffff_fffd},
		'{CMD_REM,    32'hffff_fff9, 32'h0000_0002, 5'd17, 1'b1, 32'hffff_ffff},
		'{CMD_DIV,    32'h0000_0007, 32'hffff_fffe, 5'd18, 1'b0, 32'h0},
		'{CMD_REM,    32'h0000_0007, 32'hffff_fffe, 5'd19, 1'b0, 32'h0},
		'{CMD_DIVU,   32'hffff_ffff, 32'h0000_0001, 5'd20, 1'b1, 32'hffff_ffff},
		'{CMD_DIV,    32'h8000_0000, 32'h0000_0001, 5'd21, 1'b0, 32'h0},
		'{CMD_REMU,   32'hffff_ffff, 32'h7fff_ffff, 5'd0,  1'b0, 32'h0}
	};

	initial begin
		op_row_t row;
		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = CMD_MUL;
		operand_a    = '0;
		operand_b    = '0;
		dest_reg     = '0;
		errors       = 0;
		stall_cycles = 0;
		row_fixed    = 1'b0;
		row_want     = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_ops[i])
			issue_op(directed_ops[i]);

		for (int n = 0; n < N_RANDOM; n++) begin
			row.op    = cmd_t'($urandom_range(0, 7));
			row.a     = pick_operand();
			// keep a steady share of zero divisors
			row.b     = ($urandom_range(0, 19) == 0) ? word_t'(0) : pick_operand();
			row.rd    = regnum_t'($urandom_range(0, 31));
			row.fixed = 1'b0;
			row.want  = '0;
			issue_op(row);
		end

		@(negedge clk);
		start <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("[rv32m_multiply_divide_unit_core] OK");
		else
			$display("[rv32m_multiply_divide_unit_core] ERROR");
		$finish;
	end

endmodule
